[rtl/core/apt_pkg.sv]
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types, codes and widths for the affine point transform.
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int CoordW   = 32;
    localparam int CfgIdxW  = 3;
    localparam int QueueDepthDef = 4;

    // action codes
    localparam logic [1:0] ACT_FWD     = 2'd0;
    localparam logic [1:0] ACT_FWD_DER = 2'd1;
    localparam logic [1:0] ACT_REV     = 2'd2;
    localparam logic [1:0] ACT_REV_DER = 2'd3;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_M11 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_M12 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_M21 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_M22 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TX  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_TY  = 3'd5;

    localparam logic signed [CoordW-1:0] ONE_Q24 = 32'sd16777216;

    typedef struct packed {
        logic signed [CoordW-1:0] m11;
        logic signed [CoordW-1:0] m12;
        logic signed [CoordW-1:0] m21;
        logic signed [CoordW-1:0] m22;
        logic signed [CoordW-1:0] tx;
        logic signed [CoordW-1:0] ty;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic                     fwd;    // forward class
        logic                     add_t;  // forward with translation
        logic signed [CoordW:0]   x1;
        logic signed [CoordW:0]   x2;
    } t_item;

endpackage

[rtl/core/apt_if.sv]
// ----------------------------------------------------------------------------
// apt_if
// Stream and configuration channel interfaces.
// ----------------------------------------------------------------------------
interface apt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] coord_a;
    logic [31:0] coord_b;
    modport source (output valid, action, coord_a, coord_b, input ready);
    modport sink   (input valid, action, coord_a, coord_b, output ready);
endinterface

interface apt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_a;
    logic [31:0] out_b;
    logic        saturated;
    logic        singular;
    modport source (output valid, out_a, out_b, saturated, singular, input ready);
    modport sink   (input valid, out_a, out_b, saturated, singular, output ready);
endinterface

interface apt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/apt_front.sv]
// ----------------------------------------------------------------------------
// apt_front
// Accepts input beats, classifies the action and forms the operand pair.
// ----------------------------------------------------------------------------
module apt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    apt_in_if.sink        i_in,
    input  apt_pkg::t_cfg i_cfg,
    output logic          o_valid,
    input  logic          i_ready,
    output apt_pkg::t_item o_item
);
    import apt_pkg::*;

    logic  r_v;
    t_item r_item, n_item;

    assign i_in.ready = !r_v || i_ready;
    assign o_valid    = r_v;
    assign o_item     = r_item;

    always_comb begin
        logic signed [CoordW:0] a, b;
        a = {i_in.coord_a[CoordW-1], i_in.coord_a};
        b = {i_in.coord_b[CoordW-1], i_in.coord_b};
        n_item.fwd   = 1'b0;
        n_item.add_t = 1'b0;
        n_item.x1    = a;
        n_item.x2    = b;
        unique case (i_in.action)
            ACT_FWD: begin
                n_item.fwd   = 1'b1;
                n_item.add_t = 1'b1;
            end
            ACT_FWD_DER: begin
                n_item.fwd = 1'b1;
            end
            ACT_REV: begin
                // p - T, one bit wider so it cannot wrap
                n_item.x1 = a - {i_cfg.tx[CoordW-1], i_cfg.tx};
                n_item.x2 = b - {i_cfg.ty[CoordW-1], i_cfg.ty};
            end
            ACT_REV_DER: begin
                n_item.fwd = 1'b0;
            end
            default: n_item.fwd = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in.ready) begin
            r_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item <= n_item;
        end
    end
endmodule

[rtl/core/apt_queue.sv]
// ----------------------------------------------------------------------------
// apt_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module apt_queue #(
    parameter int P_DEPTH = apt_pkg::QueueDepthDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  apt_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output apt_pkg::t_item o_item
);
    import apt_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_item          r_mem [P_DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(P_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(P_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

[rtl/core/apt_back.sv]
// ----------------------------------------------------------------------------
// apt_back
// Multiply, accumulate, forward finish and a 32-stage pipelined divider
// for the reverse actions, ending in the output register.
// ----------------------------------------------------------------------------
module apt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_pop,
    input  apt_pkg::t_item i_item,
    input  apt_pkg::t_cfg  i_cfg,
    apt_out_if.source      o_out
);
    import apt_pkg::*;

    localparam int PW = 2 * CoordW + 1;  // 32 x 33 product
    localparam int SW = PW + 1;          // sum of two products
    localparam int DW = 2 * CoordW + 1;  // determinant
    localparam int FW = SW - 24 + 1;     // forward after shift and add
    localparam int RW = 96;              // divider remainder
    localparam int QW = 32;              // quotient bits

    typedef struct packed {
        logic                 fwd;
        logic                 add_t;
        logic signed [PW-1:0] p0, p1, p2, p3;
        logic signed [2*CoordW-1:0] q0, q1;
    } t_mul;

    typedef struct packed {
        logic                 fwd;
        logic                 add_t;
        logic signed [SW-1:0] sa, sb;
        logic signed [DW-1:0] det;
    } t_sum;

    typedef struct packed {
        logic                 fwd;
        logic [CoordW-1:0]    fa, fb;
        logic                 fsat;
        logic                 sing;
        logic                 ovf_a, ovf_b;
        logic                 neg_a, neg_b;
        logic [DW-1:0]        d;
        logic [RW-1:0]        ra, rb;
        logic [QW-1:0]        qa, qb;
    } t_div;

    logic en;
    logic r_mv, r_sv, r_ov;
    logic [QW:0] r_dvv;
    t_mul r_m;
    t_sum r_s;
    t_div r_dv [QW+1];
    t_div n_dv0;

    assign en    = !r_ov || o_out.ready;
    assign o_pop = en;

    function automatic logic [CoordW:0] sat_fw(input logic signed [FW-1:0] v);
        // {flag, value}
        if (v > FW'(signed'(32'sh7fffffff)))       return {1'b1, 32'h7fffffff};
        else if (v < FW'(signed'(32'sh80000000)))  return {1'b1, 32'h80000000};
        else                                       return {1'b0, v[CoordW-1:0]};
    endfunction

    // --- multiply stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m.fwd   <= i_item.fwd;
            r_m.add_t <= i_item.add_t;
            r_m.p0 <= PW'((i_item.fwd ? i_cfg.m11 : i_cfg.m22) * i_item.x1);
            r_m.p1 <= PW'(i_cfg.m12 * i_item.x2);
            r_m.p2 <= PW'(i_cfg.m21 * i_item.x1);
            r_m.p3 <= PW'((i_item.fwd ? i_cfg.m22 : i_cfg.m11) * i_item.x2);
            r_m.q0 <= i_cfg.m11 * i_cfg.m22;
            r_m.q1 <= i_cfg.m12 * i_cfg.m21;
        end
    end

    // --- sum stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s.fwd   <= r_m.fwd;
            r_s.add_t <= r_m.add_t;
            r_s.sa  <= r_m.fwd ? SW'(r_m.p0) + SW'(r_m.p1) : SW'(r_m.p0) - SW'(r_m.p1);
            r_s.sb  <= r_m.fwd ? SW'(r_m.p2) + SW'(r_m.p3) : SW'(r_m.p3) - SW'(r_m.p2);
            r_s.det <= DW'(r_m.q0) - DW'(r_m.q1);
        end
    end

    // --- prep stage: forward finish, reverse magnitudes
    always_comb begin
        logic signed [FW-1:0] fa, fb;
        logic [CoordW:0]      sa_r, sb_r;
        logic [SW-1:0]        na, nb;
        logic [DW-1:0]        dm;
        fa = FW'(r_s.sa >>> 24);
        fb = FW'(r_s.sb >>> 24);
        if (r_s.add_t) begin
            fa = fa + FW'(i_cfg.tx);
            fb = fb + FW'(i_cfg.ty);
        end
        sa_r = sat_fw(fa);
        sb_r = sat_fw(fb);
        na = r_s.sa[SW-1] ? SW'(-r_s.sa) : SW'(r_s.sa);
        nb = r_s.sb[SW-1] ? SW'(-r_s.sb) : SW'(r_s.sb);
        dm = r_s.det[DW-1] ? DW'(-r_s.det) : DW'(r_s.det);
        n_dv0.fwd   = r_s.fwd;
        n_dv0.fa    = sa_r[CoordW-1:0];
        n_dv0.fb    = sb_r[CoordW-1:0];
        n_dv0.fsat  = sa_r[CoordW] | sb_r[CoordW];
        n_dv0.sing  = (r_s.det == '0);
        // quotient would need more than 32 bits
        n_dv0.ovf_a = ({8'b0, na} >= {dm, 8'b0});
        n_dv0.ovf_b = ({8'b0, nb} >= {dm, 8'b0});
        n_dv0.neg_a = r_s.sa[SW-1] ^ r_s.det[DW-1];
        n_dv0.neg_b = r_s.sb[SW-1] ^ r_s.det[DW-1];
        n_dv0.d     = dm;
        n_dv0.ra    = RW'({na, 24'b0});
        n_dv0.rb    = RW'({nb, 24'b0});
        n_dv0.qa    = '0;
        n_dv0.qb    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // --- restoring divider, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int SH = QW - 1 - k;
        logic [RW-1:0] dsh;
        logic          ga, gb;
        t_div          n_st;
        assign dsh = RW'(r_dv[k].d) << SH;
        assign ga  = r_dv[k].ra >= dsh;
        assign gb  = r_dv[k].rb >= dsh;
        always_comb begin
            n_st    = r_dv[k];
            n_st.ra = ga ? r_dv[k].ra - dsh : r_dv[k].ra;
            n_st.rb = gb ? r_dv[k].rb - dsh : r_dv[k].rb;
            n_st.qa = {r_dv[k].qa[QW-2:0], ga};
            n_st.qb = {r_dv[k].qb[QW-2:0], gb};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k+1] <= n_st;
            end
        end
    end

    // --- output register
    function automatic logic [CoordW:0] sign_q(input logic ovf, input logic neg,
                                               input logic [QW-1:0] q);
        if (neg) begin
            if (ovf || q > 32'h80000000) return {1'b1, 32'h80000000};
            else                         return {1'b0, 32'(-q)};
        end else begin
            if (ovf || q[QW-1])          return {1'b1, 32'h7fffffff};
            else                         return {1'b0, q};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        logic [CoordW:0] ya, yb;
        t_div            t;
        t  = r_dv[QW];
        ya = sign_q(t.ovf_a, t.neg_a, t.qa);
        yb = sign_q(t.ovf_b, t.neg_b, t.qb);
        if (en) begin
            if (t.fwd) begin
                o_out.out_a     <= t.fa;
                o_out.out_b     <= t.fb;
                o_out.saturated <= t.fsat;
                o_out.singular  <= 1'b0;
            end else if (t.sing) begin
                o_out.out_a     <= '0;
                o_out.out_b     <= '0;
                o_out.saturated <= 1'b0;
                o_out.singular  <= 1'b1;
            end else begin
                o_out.out_a     <= ya[CoordW-1:0];
                o_out.out_b     <= yb[CoordW-1:0];
                o_out.saturated <= ya[CoordW] | yb[CoordW];
                o_out.singular  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv  <= 1'b0;
            r_sv  <= 1'b0;
            r_dvv <= '0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_mv  <= i_valid;
            r_sv  <= r_mv;
            r_dvv <= {r_dvv[QW-1:0], r_sv};
            r_ov  <= r_dvv[QW];
        end
    end

    assign o_out.valid = r_ov;
endmodule

[rtl/core/affine_point_transform.sv]
// ----------------------------------------------------------------------------
// affine_point_transform
// 2-D affine map of Q16.16 points by a Q8.24 matrix, forward and reverse.
// ----------------------------------------------------------------------------
// One point is accepted per clock when the output side keeps up. Each result
// passes through one front register, the queue, multiply, sum and prep
// stages, 32 divider stages (one quotient bit each, used by the reverse
// actions and passed through by the forward ones) and the output register.
// All actions share that pipeline, so results leave in order. The user must
// write registers through the config channel only while no point is in
// flight; the block itself does not enforce it.
module affine_point_transform #(
    parameter int P_QUEUE_DEPTH = apt_pkg::QueueDepthDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    apt_in_if.sink    i_in,
    apt_cfg_if.sink   i_cfg,
    apt_out_if.source o_out
);
    import apt_pkg::*;

    t_cfg  r_cfg;
    logic  f_valid, q_full, q_valid, q_pop;
    t_item f_item, q_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.m11 <= ONE_Q24;
            r_cfg.m12 <= '0;
            r_cfg.m21 <= '0;
            r_cfg.m22 <= ONE_Q24;
            r_cfg.tx  <= '0;
            r_cfg.ty  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_M11: r_cfg.m11 <= i_cfg.data;
                REG_M12: r_cfg.m12 <= i_cfg.data;
                REG_M21: r_cfg.m21 <= i_cfg.data;
                REG_M22: r_cfg.m22 <= i_cfg.data;
                REG_TX:  r_cfg.tx  <= i_cfg.data;
                REG_TY:  r_cfg.ty  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    apt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_item  (f_item)
    );

    apt_queue #(.P_DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    apt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_item  (q_item),
        .i_cfg   (r_cfg),
        .o_out   (o_out)
    );
endmodule

[rtl/core/apt_checker.sv]
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module apt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_a,
    input logic [31:0] i_out_b,
    input logic        i_saturated,
    input logic        i_singular
);
    // singular result is all zero with no clipping
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_singular |-> i_out_a == '0 && i_out_b == '0 && !i_saturated)
        else $error("singular beat with nonzero payload");

    // a clipped beat carries a bound on one side
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |->
            i_out_a == 32'h7fffffff || i_out_a == 32'h80000000 ||
            i_out_b == 32'h7fffffff || i_out_b == 32'h80000000)
        else $error("saturated beat without a bound value");

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid just after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_a) &&
            $stable(i_out_b) && $stable(i_saturated) && $stable(i_singular))
        else $error("stalled result beat changed");
endmodule

bind affine_point_transform apt_checker u_apt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_a     (o_out.out_a),
    .i_out_b     (o_out.out_b),
    .i_saturated (o_out.saturated),
    .i_singular  (o_out.singular)
);
